### sv/ple_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ple_pkg
// Shared types, codes and defaults of the positional list engine.
// ----------------------------------------------------------------------------
package ple_pkg;

	localparam int CAPACITY_DEF = 16;

	localparam int CMD_W    = 3;
	localparam int VALUE_W  = 32;
	localparam int POS_W    = 6;
	localparam int COUNT_W  = 7;
	localparam int STATUS_W = 2;

	localparam logic [CMD_W-1:0] CMD_INS_FRONT = 3'd0;
	localparam logic [CMD_W-1:0] CMD_INS_BACK  = 3'd1;
	localparam logic [CMD_W-1:0] CMD_DEL_FRONT = 3'd2;
	localparam logic [CMD_W-1:0] CMD_DEL_BACK  = 3'd3;
	localparam logic [CMD_W-1:0] CMD_INS_AT    = 3'd4;
	localparam logic [CMD_W-1:0] CMD_DEL_AT    = 3'd5;
	localparam logic [CMD_W-1:0] CMD_DUMP      = 3'd6;

	localparam logic [STATUS_W-1:0] STAT_OK      = 2'd0;
	localparam logic [STATUS_W-1:0] STAT_BAD_POS = 2'd1;
	localparam logic [STATUS_W-1:0] STAT_FULL    = 2'd2;
	localparam logic [STATUS_W-1:0] STAT_EMPTY   = 2'd3;

	typedef struct packed {
		logic signed [VALUE_W-1:0] entry;
		logic [POS_W-1:0]          entry_index;
		logic                      last;
		logic [COUNT_W-1:0]        count;
		logic [STATUS_W-1:0]       status;
	} res_t;

endpackage

### sv/ple_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ple_in_if / ple_out_if
// Valid/ready channels for command items and result items.
// ----------------------------------------------------------------------------
interface ple_in_if import ple_pkg::*; ();
	logic                      valid;
	logic                      ready;
	logic [CMD_W-1:0]          command;
	logic signed [VALUE_W-1:0] value;
	logic [POS_W-1:0]          position;

	modport source (output valid, output command, output value, output position, input ready);
	modport sink (input valid, input command, input value, input position, output ready);
endinterface

interface ple_out_if import ple_pkg::*; ();
	logic                      valid;
	logic                      ready;
	logic signed [VALUE_W-1:0] entry;
	logic [POS_W-1:0]          entry_index;
	logic                      last;
	logic [COUNT_W-1:0]        count;
	logic [STATUS_W-1:0]       status;

	modport source (output valid, output entry, output entry_index, output last,
		output count, output status, input ready);
	modport sink (input valid, input entry, input entry_index, input last,
		input count, input status, output ready);
endinterface

### sv/positional_list_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// positional_list_engine
// Bounded ordered list of signed 32-bit words with positional insert/delete.
// ----------------------------------------------------------------------------
// Usage:
//   cmd carries one command item (command, value, position); res carries
//   result items (entry, entry_index, last, count, status). Both are
//   valid/ready channels; an item moves when valid and ready are high.
//   Each command item gives one result item, except a dump of a non-empty
//   list, which gives one result per entry with last on the final one.
//   An insert or delete shifts the entries behind the touched position one
//   at a time through the list RAM: the command is taken, each moved entry
//   is read and then written back, an insert writes the new word, and the
//   result is given. A dump reads each entry and then gives its result.
//   Rejected commands go straight to the result.
//   cmd.ready is high only between commands. Results leave through an
//   output register, so the sequencer returns to idle while the last result
//   waits; a stalled receiver holds the register and then the sequencer.
//   Reset empties the list at once.
// ----------------------------------------------------------------------------
module positional_list_engine import ple_pkg::*; #(
	parameter int CAPACITY = CAPACITY_DEF
) (
	input  logic      clk,
	input  logic      arst_n,
	ple_in_if.sink    cmd,
	ple_out_if.source res
);

	logic res_valid;
	logic res_ready;
	res_t res_data;
	logic out_valid_q;
	res_t out_q;

	assign res_ready = !out_valid_q || res.ready;

	ple_seq #(
		.CAPACITY(CAPACITY)
	) u_ple_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.res_valid(res_valid),
		.res_ready(res_ready),
		.res_data (res_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_ready) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ready && res_valid) begin
			out_q <= res_data;
		end
	end

	assign res.valid       = out_valid_q;
	assign res.entry       = out_q.entry;
	assign res.entry_index = out_q.entry_index;
	assign res.last        = out_q.last;
	assign res.count       = out_q.count;
	assign res.status      = out_q.status;

endmodule

### sv/ple_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ple_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ple_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata_q
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

endmodule

### sv/ple_seq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ple_seq
// Command sequencer: checks each item, moves entries one at a time through
// the shared index adder and the list RAM, and produces result items.
// ----------------------------------------------------------------------------
module ple_seq import ple_pkg::*; #(
	parameter int CAPACITY = CAPACITY_DEF
) (
	input  logic    clk,
	input  logic    arst_n,
	ple_in_if.sink  cmd,
	output logic    res_valid,
	input  logic    res_ready,
	output res_t    res_data
);

	localparam int IW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);
	localparam logic [CW-1:0] CAP = CW'(CAPACITY);

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_MV_RD  = 3'd1;
	localparam logic [2:0] S_MV_WR  = 3'd2;
	localparam logic [2:0] S_INS_WR = 3'd3;
	localparam logic [2:0] S_RESP   = 3'd4;
	localparam logic [2:0] S_DP_RD  = 3'd5;
	localparam logic [2:0] S_DP_OUT = 3'd6;

	logic [2:0]                state_q;
	logic [CW-1:0]             count_q;
	logic [CW-1:0]             idx_q;
	logic [CW-1:0]             slot_q;
	logic                      ins_q;
	logic [STATUS_W-1:0]       status_q;
	logic signed [VALUE_W-1:0] val_q;

	logic [CW-1:0]      adj;
	logic [CW:0]        adj_p1;
	logic [COUNT_W-1:0] pos7;
	logic [COUNT_W-1:0] cnt7;
	logic               empty;
	logic               full;
	logic [CW-1:0]      pos_slot;
	logic               ram_we;
	logic [IW-1:0]      ram_waddr;
	logic [VALUE_W-1:0] ram_wdata;
	logic               ram_re;
	logic [IW-1:0]      ram_raddr;
	logic [VALUE_W-1:0] ram_rdata;
	logic               dump_last;

	logic [2:0]          dec_state;
	logic [STATUS_W-1:0] dec_status;
	logic                dec_ins;
	logic [CW-1:0]       dec_idx;
	logic [CW-1:0]       dec_slot;
	logic [CW-1:0]       dec_count;

	// shared index unit: step down for inserts, up for deletes and dumps
	assign adj    = idx_q + (ins_q ? {CW{1'b1}} : CW'(1));
	assign adj_p1 = {1'b0, adj} + (CW + 1)'(1);

	assign pos7     = COUNT_W'(cmd.position);
	assign cnt7     = COUNT_W'(count_q);
	assign empty    = (count_q == '0);
	assign full     = (count_q >= CAP);
	assign pos_slot = CW'(cmd.position - POS_W'(1));
	assign dump_last = (adj == count_q);

	assign cmd.ready = (state_q == S_IDLE);

	// command decode for the item at the input
	always_comb begin
		dec_state  = S_RESP;
		dec_status = STAT_OK;
		dec_ins    = 1'b0;
		dec_idx    = idx_q;
		dec_slot   = slot_q;
		dec_count  = count_q;
		case (cmd.command) inside
			CMD_INS_FRONT, CMD_INS_BACK, CMD_INS_AT: begin
				if (cmd.command == CMD_INS_AT &&
					(cmd.position == '0 || pos7 > cnt7 + COUNT_W'(1))) begin
					dec_status = STAT_BAD_POS;
				end else if (full) begin
					dec_status = STAT_FULL;
				end else begin
					dec_ins = 1'b1;
					dec_idx = count_q;
					if (cmd.command == CMD_INS_FRONT) begin
						dec_slot  = '0;
						dec_state = empty ? S_INS_WR : S_MV_RD;
					end else if (cmd.command == CMD_INS_BACK) begin
						dec_slot  = count_q;
						dec_state = S_INS_WR;
					end else begin
						dec_slot  = pos_slot;
						dec_state = (count_q > pos_slot) ? S_MV_RD : S_INS_WR;
					end
				end
			end
			CMD_DEL_FRONT, CMD_DEL_BACK, CMD_DEL_AT: begin
				if (empty) begin
					dec_status = STAT_EMPTY;
				end else if (cmd.command == CMD_DEL_AT &&
					(cmd.position == '0 || pos7 > cnt7)) begin
					dec_status = STAT_BAD_POS;
				end else if (cmd.command == CMD_DEL_BACK) begin
					dec_count = count_q - CW'(1);
				end else begin
					dec_idx = (cmd.command == CMD_DEL_FRONT) ? '0 : pos_slot;
					if (((cmd.command == CMD_DEL_FRONT) ? CW'(1)
						: pos_slot + CW'(1)) < count_q) begin
						dec_state = S_MV_RD;
					end else begin
						dec_count = count_q - CW'(1);
					end
				end
			end
			CMD_DUMP: begin
				if (empty) begin
					dec_status = STAT_EMPTY;
				end else begin
					dec_idx   = '0;
					dec_state = S_DP_RD;
				end
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = idx_q[IW-1:0];
		ram_wdata = ram_rdata;
		ram_re    = 1'b0;
		ram_raddr = adj[IW-1:0];
		res_valid = 1'b0;
		res_data  = '{entry: '0, entry_index: '0, last: 1'b1, count: cnt7, status: status_q};
		unique case (state_q)
			S_MV_RD: begin
				ram_re = 1'b1;
			end
			S_MV_WR: begin
				ram_we = 1'b1;
			end
			S_INS_WR: begin
				ram_we    = 1'b1;
				ram_waddr = slot_q[IW-1:0];
				ram_wdata = val_q;
			end
			S_RESP: begin
				res_valid = 1'b1;
			end
			S_DP_RD: begin
				ram_re    = 1'b1;
				ram_raddr = idx_q[IW-1:0];
			end
			S_DP_OUT: begin
				res_valid = 1'b1;
				res_data  = '{entry: ram_rdata, entry_index: POS_W'(adj), last: dump_last,
					count: cnt7, status: STAT_OK};
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			count_q  <= '0;
			idx_q    <= '0;
			slot_q   <= '0;
			ins_q    <= 1'b0;
			status_q <= STAT_OK;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (cmd.valid) begin
						state_q  <= dec_state;
						status_q <= dec_status;
						ins_q    <= dec_ins;
						idx_q    <= dec_idx;
						slot_q   <= dec_slot;
						count_q  <= dec_count;
					end
				end
				S_MV_RD: begin
					state_q <= S_MV_WR;
				end
				S_MV_WR: begin
					idx_q <= adj;
					if (ins_q) begin
						state_q <= (adj > slot_q) ? S_MV_RD : S_INS_WR;
					end else if (adj_p1 < {1'b0, count_q}) begin
						state_q <= S_MV_RD;
					end else begin
						count_q <= count_q - CW'(1);
						state_q <= S_RESP;
					end
				end
				S_INS_WR: begin
					count_q <= count_q + CW'(1);
					state_q <= S_RESP;
				end
				S_RESP: begin
					if (res_ready) begin
						state_q <= S_IDLE;
					end
				end
				S_DP_RD: begin
					state_q <= S_DP_OUT;
				end
				S_DP_OUT: begin
					if (res_ready) begin
						idx_q   <= adj;
						state_q <= dump_last ? S_IDLE : S_DP_RD;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.valid && cmd.ready) begin
			val_q <= cmd.value;
		end
	end

	ple_ram #(
		.WIDTH(VALUE_W),
		.DEPTH(CAPACITY)
	) u_ple_ram (
		.clk    (clk),
		.we     (ram_we),
		.waddr  (ram_waddr),
		.wdata  (ram_wdata),
		.re     (ram_re),
		.raddr  (ram_raddr),
		.rdata_q(ram_rdata)
	);

endmodule

### sv/ple_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ple_checker
// Port-level checks of the positional list engine, bound to the top level.
// ----------------------------------------------------------------------------
module ple_checker import ple_pkg::*; #(
	parameter int CAPACITY = CAPACITY_DEF
) (
	input logic                clk,
	input logic                arst_n,
	input logic                in_valid,
	input logic                in_ready,
	input logic                out_valid,
	input logic                out_ready,
	input logic [POS_W-1:0]    out_entry_index,
	input logic                out_last,
	input logic [COUNT_W-1:0]  out_count,
	input logic [STATUS_W-1:0] out_status
);

	// the engine works on one command item at a time
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
	else $error("ple: ready stayed high after accepting an item");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_entry_index) && $stable(out_last))
	else $error("ple: stalled result item changed");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_count <= COUNT_W'(CAPACITY))
	else $error("ple: count above capacity");

	// dumped entries carry a position inside the list
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_entry_index != '0 |->
			out_status == STAT_OK && COUNT_W'(out_entry_index) <= out_count)
	else $error("ple: dump index out of range");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_last |-> out_entry_index != '0 && out_status == STAT_OK)
	else $error("ple: non-final result outside a dump");

endmodule

bind positional_list_engine ple_checker #(
	.CAPACITY(CAPACITY)
) u_ple_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.in_valid       (cmd.valid),
	.in_ready       (cmd.ready),
	.out_valid      (res.valid),
	.out_ready      (res.ready),
	.out_entry_index(res.entry_index),
	.out_last       (res.last),
	.out_count      (res.count),
	.out_status     (res.status)
);
